FILE: sv/vdi_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and compare functions for the vertex de-duplication indexer.
package vdi_pkg;

   localparam int FIELD_WIDTH = 24;
   localparam int TOL_WIDTH   = 23;
   localparam int OUT_IDX_W   = 8;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 23'd41;

   typedef logic signed [FIELD_WIDTH-1:0] field_type;
   typedef logic [TOL_WIDTH-1:0] tol_type;

   typedef struct packed {
      logic      restart;
      field_type pos_x;
      field_type pos_y;
      field_type pos_z;
      field_type tex_u;
      field_type tex_v;
      field_type norm_x;
      field_type norm_y;
      field_type norm_z;
   } req_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] vertex_index;
      logic                 is_new;
      logic                 table_full;
   } rsp_type;

   typedef struct packed {
      field_type pos_x;
      field_type pos_y;
      field_type pos_z;
      field_type tex_u;
      field_type tex_v;
      field_type norm_x;
      field_type norm_y;
      field_type norm_z;
   } vertex_type;

   // Search token that walks down the cell chain.
   typedef struct packed {
      logic active;
      logic hit;
      logic is_new;
   } token_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_HOLD
   } state_type;

   // True when |a - b| is strictly below the tolerance.
   function automatic logic field_close(input field_type a, input field_type b,
                                        input tol_type tol);
      logic signed [FIELD_WIDTH:0] diff;
      logic [FIELD_WIDTH:0]        mag;
      diff = {a[FIELD_WIDTH-1], a} - {b[FIELD_WIDTH-1], b};
      mag  = diff[FIELD_WIDTH] ? unsigned'(-diff) : unsigned'(diff);
      return mag < {{(FIELD_WIDTH + 1 - TOL_WIDTH){1'b0}}, tol};
   endfunction

   function automatic logic vertex_close(input vertex_type a, input vertex_type b,
                                         input tol_type tol);
      return field_close(a.pos_x, b.pos_x, tol) &&
             field_close(a.pos_y, b.pos_y, tol) &&
             field_close(a.pos_z, b.pos_z, tol) &&
             field_close(a.tex_u, b.tex_u, tol) &&
             field_close(a.tex_v, b.tex_v, tol) &&
             field_close(a.norm_x, b.norm_x, tol) &&
             field_close(a.norm_y, b.norm_y, tol) &&
             field_close(a.norm_z, b.norm_z, tol);
   endfunction

endpackage

FILE: sv/vertex_dedup_indexer_top.sv
`timescale 1ns / 1ps
// Vertex de-duplication indexer: one item in flight, searched by a chain of TABLE_DEPTH cells.
// The search token walks down the chain one cell per cycle, and the result is captured
// as it leaves the last cell. A new item is taken only once the previous result is loaded.
// A new item may be accepted while the previous result still waits in the output register.
// Reset empties the table (entry count 0), sets the tolerance to 41 and clears all handshakes.
module vertex_dedup_indexer_top #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  vdi_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output vdi_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [vdi_pkg::TOL_WIDTH-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   vdi_pkg::state_type  state_ff, state_in;
   vdi_pkg::tol_type    tol_ff;
   vdi_pkg::vertex_type query_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                start_ff;
   vdi_pkg::token_type  res_tok_ff;
   logic [IDX_W-1:0]    res_idx_ff;
   logic                rsp_valid_ff;
   vdi_pkg::rsp_type    rsp_data_ff;

   vdi_pkg::token_type  tok   [TABLE_DEPTH+1];
   logic [IDX_W-1:0]    idx   [TABLE_DEPTH+1];

   logic                accept;
   logic                exit_valid;
   logic                out_free;
   logic                capture;
   logic                load_out;
   logic [IDX_W+vdi_pkg::OUT_IDX_W-1:0] idx_wide;

   assign accept     = req_valid && !req_stall;
   assign exit_valid = tok[TABLE_DEPTH].active;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign tok[0] = '{active: start_ff, hit: 1'b0, is_new: 1'b0};
   assign idx[0] = '0;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      vdi_cell #(
         .CELL_INDEX(g),
         .CNT_W     (CNT_W),
         .IDX_W     (IDX_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tolerance(tol_ff),
         .query    (query_ff),
         .count    (count_ff),
         .tok_in   (tok[g]),
         .idx_in   (idx[g]),
         .tok_out  (tok[g+1]),
         .idx_out  (idx[g+1])
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vdi_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = vdi_pkg::ST_SEARCH;
            end
         end
         vdi_pkg::ST_SEARCH: begin
            if (exit_valid) begin
               state_in = vdi_pkg::ST_HOLD;
            end
         end
         vdi_pkg::ST_HOLD: begin
            if (out_free) begin
               state_in = vdi_pkg::ST_IDLE;
            end
         end
         default: state_in = vdi_pkg::ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall = 1'b1;
      capture   = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         vdi_pkg::ST_IDLE:   req_stall = 1'b0;
         vdi_pkg::ST_SEARCH: capture   = exit_valid;
         vdi_pkg::ST_HOLD:   load_out  = out_free;
         default:            req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vdi_pkg::ST_IDLE;
         tol_ff       <= vdi_pkg::TOL_RESET;
         count_ff     <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= accept;
         if (csr_we) begin
            tol_ff <= csr_wdata;
         end
         if (accept && req_data.restart) begin
            count_ff <= '0;
         end else if (capture && tok[TABLE_DEPTH].is_new) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign idx_wide = {{vdi_pkg::OUT_IDX_W{1'b0}}, res_idx_ff};

   always_ff @(posedge clock) begin
      if (accept) begin
         query_ff.pos_x  <= req_data.pos_x;
         query_ff.pos_y  <= req_data.pos_y;
         query_ff.pos_z  <= req_data.pos_z;
         query_ff.tex_u  <= req_data.tex_u;
         query_ff.tex_v  <= req_data.tex_v;
         query_ff.norm_x <= req_data.norm_x;
         query_ff.norm_y <= req_data.norm_y;
         query_ff.norm_z <= req_data.norm_z;
      end
      if (capture) begin
         res_tok_ff <= tok[TABLE_DEPTH];
         res_idx_ff <= idx[TABLE_DEPTH];
      end
      if (load_out) begin
         // A token that leaves the chain without a hit means no match and no room.
         rsp_data_ff.vertex_index <= res_tok_ff.hit ? idx_wide[vdi_pkg::OUT_IDX_W-1:0] : '0;
         rsp_data_ff.is_new       <= res_tok_ff.is_new;
         rsp_data_ff.table_full   <= !res_tok_ff.hit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: sv/vdi_cell.sv
`timescale 1ns / 1ps
// One table cell: holds a unique vertex and advances the search token by one step.
module vdi_cell #(
   parameter int CELL_INDEX = 0,
   parameter int CNT_W      = 9,
   parameter int IDX_W      = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  vdi_pkg::tol_type     tolerance,
   input  vdi_pkg::vertex_type  query,
   input  logic [CNT_W-1:0]     count,
   input  vdi_pkg::token_type   tok_in,
   input  logic [IDX_W-1:0]     idx_in,
   output vdi_pkg::token_type   tok_out,
   output logic [IDX_W-1:0]     idx_out
);

   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   vdi_pkg::vertex_type entry_ff;
   vdi_pkg::token_type  tok_ff, tok_in_next;
   logic [IDX_W-1:0]    idx_ff, idx_in_next;
   logic                write_en;
   logic                occupied;
   logic                vacant_head;
   logic                match;

   assign occupied    = MY_CNT < count;
   assign vacant_head = MY_CNT == count;
   assign match       = vdi_pkg::vertex_close(query, entry_ff, tolerance);

   always_comb begin
      tok_in_next = tok_in;
      idx_in_next = idx_in;
      write_en    = 1'b0;
      if (tok_in.active && !tok_in.hit) begin
         if (occupied && match) begin
            tok_in_next.hit = 1'b1;
            idx_in_next     = MY_IDX;
         end else if (vacant_head) begin
            // First free slot reached without a match: the vertex lands here.
            tok_in_next.hit    = 1'b1;
            tok_in_next.is_new = 1'b1;
            idx_in_next        = MY_IDX;
            write_en           = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in_next;
      if (write_en) begin
         entry_ff <= query;
      end
   end

   assign tok_out = tok_ff;
   assign idx_out = idx_ff;

endmodule

FILE: sim/vertex_dedup_indexer_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the vertex de-duplication indexer with a built-in table predictor.
module vertex_dedup_indexer_top_test;

   localparam int TABLE_DEPTH = 256;
   localparam int FIELDS      = 8;
   localparam int STALL_LIMIT = 5000;
   localparam int TOL_MAX     = (1 << vdi_pkg::TOL_WIDTH) - 1;
   localparam longint FIELD_MAX = (64'sd1 <<< (vdi_pkg::FIELD_WIDTH - 1)) - 1;
   localparam longint FIELD_MIN = -(64'sd1 <<< (vdi_pkg::FIELD_WIDTH - 1));

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   vdi_pkg::req_type              req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   vdi_pkg::rsp_type              rsp_data;
   logic                          csr_we = 1'b0;
   logic [vdi_pkg::TOL_WIDTH-1:0] csr_wdata = '0;

   vertex_dedup_indexer_top #(.TABLE_DEPTH(TABLE_DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: a copy of the unique-vertex table and the tolerance.
   longint  unique_table [TABLE_DEPTH][FIELDS];
   int      unique_count = 0;
   int      tolerance_model = int'(vdi_pkg::TOL_RESET);

   vdi_pkg::req_type pending_vertices[$];
   vdi_pkg::req_type recent_vertices[$];
   vdi_pkg::rsp_type expected_indices[$];
   int      items_queued = 0;
   int      results_checked = 0;
   int      mismatches = 0;
   int      idle_cycles = 0;
   int      sender_idle_pct = 0;
   int      receiver_stall_pct = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void fields_of(input vdi_pkg::req_type v, output longint f[FIELDS]);
      f[0] = longint'(v.pos_x);
      f[1] = longint'(v.pos_y);
      f[2] = longint'(v.pos_z);
      f[3] = longint'(v.tex_u);
      f[4] = longint'(v.tex_v);
      f[5] = longint'(v.norm_x);
      f[6] = longint'(v.norm_y);
      f[7] = longint'(v.norm_z);
   endfunction

   function automatic bit vertex_near(input longint a[FIELDS], input int slot);
      longint d;
      for (int k = 0; k < FIELDS; k++) begin
         d = a[k] - unique_table[slot][k];
         if (d < 0) d = -d;
         if (d >= longint'(tolerance_model)) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Lowest matching entry wins; otherwise append, or flag a full table.
   function automatic vdi_pkg::rsp_type index_vertex(input vdi_pkg::req_type item);
      longint  f [FIELDS];
      vdi_pkg::rsp_type res;
      int      hit;
      fields_of(item, f);
      if (item.restart) unique_count = 0;
      hit = -1;
      for (int i = 0; i < unique_count && hit < 0; i++) begin
         if (vertex_near(f, i)) hit = i;
      end
      res = '0;
      if (hit >= 0) begin
         res.vertex_index = hit[vdi_pkg::OUT_IDX_W-1:0];
      end else if (unique_count >= TABLE_DEPTH) begin
         res.table_full = 1'b1;
      end else begin
         for (int k = 0; k < FIELDS; k++) unique_table[unique_count][k] = f[k];
         res.vertex_index = unique_count[vdi_pkg::OUT_IDX_W-1:0];
         res.is_new = 1'b1;
         unique_count++;
      end
      return res;
   endfunction

   task automatic queue_vertex(input bit rst, input longint f[FIELDS]);
      vdi_pkg::req_type v;
      v.restart = rst;
      v.pos_x   = f[0][vdi_pkg::FIELD_WIDTH-1:0];
      v.pos_y   = f[1][vdi_pkg::FIELD_WIDTH-1:0];
      v.pos_z   = f[2][vdi_pkg::FIELD_WIDTH-1:0];
      v.tex_u   = f[3][vdi_pkg::FIELD_WIDTH-1:0];
      v.tex_v   = f[4][vdi_pkg::FIELD_WIDTH-1:0];
      v.norm_x  = f[5][vdi_pkg::FIELD_WIDTH-1:0];
      v.norm_y  = f[6][vdi_pkg::FIELD_WIDTH-1:0];
      v.norm_z  = f[7][vdi_pkg::FIELD_WIDTH-1:0];
      if (rst) recent_vertices.delete();
      recent_vertices.insert(recent_vertices.size(), v);
      pending_vertices.insert(pending_vertices.size(), v);
      items_queued++;
   endtask

   task automatic queue_uniform(input bit rst, input longint value, input int odd_field = -1,
                                input longint odd_value = 0);
      longint f [FIELDS];
      for (int k = 0; k < FIELDS; k++) f[k] = value;
      if (odd_field >= 0) f[odd_field] = odd_value;
      queue_vertex(rst, f);
   endtask

   function automatic longint random_field(input int mode);
      if (mode == 7) return $urandom_range(0, 1) ? FIELD_MAX : FIELD_MIN;
      if (mode >= 8) return longint'(int'($urandom_range(0, 200)) - 100);
      return longint'(vdi_pkg::field_type'($urandom()));
   endfunction

   // A run of vertices after a restart: fresh ones, and copies of earlier ones moved
   // within the tolerance, some with one field pushed just past it.
   task automatic send_segment(input int length, input int near_pct);
      longint f [FIELDS];
      int     mode;
      int     span;
      int     breaker;
      int     off;
      for (int n = 0; n < length; n++) begin
         if (n > 0 && recent_vertices.size() > 0 && $urandom_range(0, 99) < near_pct) begin
            fields_of(recent_vertices[$urandom_range(0, recent_vertices.size() - 1)], f);
            span = (tolerance_model > 0) ? tolerance_model - 1 : 0;
            breaker = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, FIELDS - 1)) : -1;
            for (int k = 0; k < FIELDS; k++) begin
               case ($urandom_range(0, 3))
                  0: off = span;
                  1: off = -span;
                  2: off = 0;
                  default: off = int'($urandom_range(0, 2 * span)) - span;
               endcase
               if (k == breaker) begin
                  off = tolerance_model + int'($urandom_range(0, 3));
                  if ($urandom_range(0, 1)) off = -off;
               end
               f[k] = f[k] + off;
            end
         end else begin
            mode = $urandom_range(0, 9);
            for (int k = 0; k < FIELDS; k++) f[k] = random_field(mode);
         end
         queue_vertex(n == 0 || $urandom_range(0, 99) < 2, f);
      end
   endtask

   task automatic write_tolerance(input int value);
      while (results_checked != items_queued) @(posedge clock);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value[vdi_pkg::TOL_WIDTH-1:0];
      tolerance_model = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Driver: presents pending items and predicts each one as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_indices.insert(expected_indices.size(), index_vertex(req_data));
         if (!req_valid || !req_stall) begin
            if (pending_vertices.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_vertices.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result against the oldest prediction.
   always @(posedge clock) begin
      vdi_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_indices.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result index %0d new %0b full %0b", $realtime,
                           rsp_data.vertex_index, rsp_data.is_new, rsp_data.table_full);
            end else begin
               want = expected_indices.pop_front();
               if (rsp_data.vertex_index !== want.vertex_index || rsp_data.is_new !== want.is_new
                   || rsp_data.table_full !== want.table_full) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: result mismatch index exp %0d got %0d, ",
                               "new exp %0b got %0b, full exp %0b got %0b"},
                              $realtime, want.vertex_index, rsp_data.vertex_index, want.is_new,
                              rsp_data.is_new, want.table_full, rsp_data.table_full);
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("vertex_dedup_indexer_top verification failed");
            $finish;
         end
      end
   end

   initial begin
      longint f [FIELDS];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = 31;
      receiver_stall_pct = 50;

      // Directed part at the reset tolerance: exact and near hits, each field just out of
      // range, field extremes, bit patterns and restarts.
      queue_uniform(1'b1, 0);
      queue_uniform(1'b0, 0);
      queue_uniform(1'b0, 40);
      queue_uniform(1'b0, -40);
      for (int k = 0; k < FIELDS; k++) queue_uniform(1'b0, 0, k, (k % 2) ? -41 : 41);
      queue_uniform(1'b0, FIELD_MAX);
      queue_uniform(1'b0, FIELD_MIN);
      queue_uniform(1'b0, FIELD_MAX - 40);
      queue_uniform(1'b0, FIELD_MIN + 40);
      for (int k = 0; k < FIELDS; k++) f[k] = (k % 2) ? FIELD_MIN : FIELD_MAX;
      queue_vertex(1'b0, f);
      queue_uniform(1'b0, 5592405);
      queue_uniform(1'b0, -5592406);
      queue_uniform(1'b1, FIELD_MAX);
      queue_uniform(1'b0, 0);
      queue_uniform(1'b1, 0);

      // A long segment, then shorter segments; any of them may restart the table along the way.
      send_segment(380, 20);
      while (items_queued < 600) send_segment($urandom_range(10, 60), 40);

      write_tolerance(0);
      send_segment(40, 70);

      write_tolerance(TOL_MAX);
      sender_idle_pct = 50;
      receiver_stall_pct = 31;
      while (items_queued < 820) send_segment($urandom_range(10, 60), 50);
      write_tolerance(1);
      while (items_queued < 1020) send_segment($urandom_range(10, 60), 50);

      write_tolerance($urandom_range(2, 4096));
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_segment(380, 20);
      write_tolerance(int'(vdi_pkg::TOL_RESET));
      while (items_queued < 1650) send_segment($urandom_range(10, 60), 40);

      while (results_checked != items_queued) @(posedge clock);
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (mismatches == 0 && expected_indices.size() == 0) begin
         $display("vertex_dedup_indexer_top verification clean");
      end else begin
         $display("vertex_dedup_indexer_top verification failed");
      end
      $finish;
   end

endmodule
